// ----- sv/slope_sum_peak_detector_assert.svh -----
// ---------------------------------------------------------------------------
// slope sum peak detector assertion macros
// shared property forms for the port-level checks
// ---------------------------------------------------------------------------
`ifndef SLOPE_SUM_PEAK_DETECTOR_ASSERT_SVH
`define SLOPE_SUM_PEAK_DETECTOR_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SSPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slope_sum_peak_detector: check failed");

// consequent in the cycle after the antecedent
`define SSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slope_sum_peak_detector: check failed");

`endif

// ----- sv/sspd_pkg.sv -----
// ---------------------------------------------------------------------------
// sspd_pkg
// types and constants shared by the slope sum peak detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sspd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + 1;
    localparam int POS_W      = 16;
    localparam int J_W        = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int WIN_CFG_W  = 6;
    localparam int THR_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITIONS = 2'd2;

    localparam logic [WIN_CFG_W-1:0]   WINDOW_RESET    = 6'd8;
    localparam logic signed [THR_W-1:0] THRESHOLD_RESET = -17'sd30;
    localparam logic [POS_W-1:0]       MAX_POS_RESET   = 16'd16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] peak_position;
        logic [POS_W-1:0] peak_count;
        logic             position_stored;
    } t_out_item;

    // scan token handed from cell to cell, oldest sample toward newest
    typedef struct packed {
        logic                       valid;
        logic                       ok;
        logic signed [SAMPLE_W-1:0] best;
        logic [J_W-1:0]             jbest;
    } t_scan;

endpackage

// ----- sv/slope_sum_peak_detector.sv -----
// ---------------------------------------------------------------------------
// slope_sum_peak_detector
// slope sum peak detection over a framed stream of signed samples
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with a t_in_item payload. A sample
// with start_of_frame set restarts the frame index, history fill and peak
// count. Output channel: o_out_valid / i_out_stall with a t_out_item payload,
// zero or one transaction per input sample. Config channel: i_cfg_valid /
// o_cfg_ready, always ready; write only while the block is idle.
// The history is a row of MAX_WINDOW+2 cells. A sample is shifted in at the
// input transaction; when enough history is held a scan token walks from the
// oldest cell of the window to the newest, one cell per cycle, tracking the
// largest rising sample. The input is held off while the token walks and, when
// a peak is found, until the result enters the output register; a sample that
// starts no walk leaves the block idle, ready for the next sample.
// The result sits in an output register, so the next sample is taken while
// it waits; a stalled result holds and a new result waits behind it.
// Reset restores the register defaults and clears index, fill and count; the
// history cells need no clearing since they are never read before written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slope_sum_peak_detector
    import sspd_pkg::*;
#(
    parameter int MAX_WINDOW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int HIST_DEPTH = MAX_WINDOW + 2;
    localparam int IDX_W      = $clog2(MAX_WINDOW + 3);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // configuration
    logic [WIN_CFG_W-1:0]   r_cfg_win;
    logic signed [THR_W-1:0] r_cfg_thr;
    logic [POS_W-1:0]       r_cfg_maxpos;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [POS_W-1:0] r_index, n_index;
    logic [POS_W-1:0] r_total, n_total;
    logic             r_start, n_start;
    logic [J_W-1:0]   r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic [POS_W-1:0] r_base, n_base;
    logic [POS_W-1:0] r_pend_pos, n_pend_pos;
    t_out_item        r_out_data, n_out_data;

    logic [IDX_W-1:0] w_win;
    logic [IDX_W-1:0] w_head_sel;
    logic             w_in_acc;
    logic             w_out_free;
    logic [IDX_W-1:0] w_fill_base;
    logic [POS_W-1:0] w_index_cur;
    logic             w_detect;

    logic signed [SAMPLE_W-1:0] w_hist [HIST_DEPTH];
    t_scan                      w_tok  [HIST_DEPTH];

    // effective window, clamped to the supported range
    always_comb begin
        if (r_cfg_win < WIN_CFG_W'(2)) begin
            w_win = IDX_W'(2);
        end else if (32'(r_cfg_win) > 32'(MAX_WINDOW)) begin
            w_win = IDX_W'(MAX_WINDOW);
        end else begin
            w_win = IDX_W'(r_cfg_win);
        end
    end

    assign w_head_sel = w_win + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win    <= WINDOW_RESET;
            r_cfg_thr    <= THRESHOLD_RESET;
            r_cfg_maxpos <= MAX_POS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE:   r_cfg_win    <= i_cfg_data[WIN_CFG_W-1:0];
                CFG_SUM_THRESHOLD: r_cfg_thr    <= $signed(i_cfg_data[THR_W-1:0]);
                CFG_MAX_POSITIONS: r_cfg_maxpos <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // history row and scan chain
    genvar k;
    generate
        for (k = 0; k < HIST_DEPTH; k++) begin : g_cell
            logic signed [SAMPLE_W-1:0] w_newer;
            t_scan                      w_tok_in;

            if (k == 0) begin : g_first
                assign w_newer = i_in_data.sample;
            end else begin : g_chain
                assign w_newer = w_hist[k-1];
            end

            if (k >= 2 && k < HIST_DEPTH - 1) begin : g_tok
                assign w_tok_in = w_tok[k+1];
            end else begin : g_no_tok
                assign w_tok_in = '0;
            end

            sspd_cell #(
                .K          (k),
                .MAX_WINDOW (MAX_WINDOW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_in_acc),
                .i_start    (r_start),
                .i_head_sel (w_head_sel),
                .i_step     (r_step),
                .i_thr      (r_cfg_thr),
                .i_newer    (w_newer),
                .i_hist0    (w_hist[0]),
                .i_hist1    (w_hist[1]),
                .i_tok      (w_tok_in),
                .o_sample   (w_hist[k]),
                .o_tok      (w_tok[k])
            );
        end
    endgenerate

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fill_base = i_in_data.start_of_frame ? '0 : r_fill;
    assign w_index_cur = i_in_data.start_of_frame ? '0 : r_index;
    // falling slope at the end of the window, on top of the head checks
    assign w_detect    = w_tok[2].ok && (w_hist[1] < w_hist[2]);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_index     = r_index;
        n_total     = r_total;
        n_start     = 1'b0;
        n_step      = r_step;
        n_base      = r_base;
        n_pend_pos  = r_pend_pos;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_fill  = (w_fill_base < IDX_W'(HIST_DEPTH))
                              ? w_fill_base + IDX_W'(1) : w_fill_base;
                    n_index = w_index_cur + POS_W'(1);
                    n_base  = w_index_cur - POS_W'(w_win) - POS_W'(1);
                    if (i_in_data.start_of_frame) begin
                        n_total = '0;
                    end
                    if (n_fill >= w_win + IDX_W'(2)) begin
                        n_start = 1'b1;
                        n_step  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_step = r_step + J_W'(1);
                if (w_tok[2].valid) begin
                    n_pend_pos = r_base + POS_W'(w_tok[2].jbest);
                    n_state    = w_detect ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data.peak_position   = r_pend_pos;
                    n_out_data.position_stored = r_total < r_cfg_maxpos;
                    n_total                    = (r_total != '1)
                                                 ? r_total + POS_W'(1) : r_total;
                    n_out_data.peak_count      = n_total;
                    n_state                    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_index     <= '0;
            r_total     <= '0;
            r_start     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_index     <= n_index;
            r_total     <= n_total;
            r_start     <= n_start;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_pend_pos <= n_pend_pos;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- sv/sspd_cell.sv -----
// ---------------------------------------------------------------------------
// sspd_cell
// one history cell: holds a sample and runs one step of the window scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspd_cell
    import sspd_pkg::*;
#(
    parameter int K          = 2,
    parameter int MAX_WINDOW = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic                       i_start,
    input  logic [$clog2(MAX_WINDOW+3)-1:0] i_head_sel,
    input  logic [J_W-1:0]             i_step,
    input  logic signed [THR_W-1:0]    i_thr,
    input  logic signed [SAMPLE_W-1:0] i_newer,
    input  logic signed [SAMPLE_W-1:0] i_hist0,
    input  logic signed [SAMPLE_W-1:0] i_hist1,
    input  t_scan                      i_tok,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output t_scan                      o_tok
);

    localparam int IDX_W = $clog2(MAX_WINDOW + 3);

    logic signed [SAMPLE_W-1:0] r_sample;
    t_scan                      r_tok;
    t_scan                      w_cur;
    t_scan                      n_tok;
    logic                       w_head;
    logic signed [SUM_W-1:0]    w_sum_i;
    logic signed [SUM_W-1:0]    w_sum_next;
    logic                       w_rise;
    logic                       w_elig;

    assign w_head     = i_start && (i_head_sel == IDX_W'(K));
    assign w_rise     = i_newer > r_sample;
    assign w_sum_i    = SUM_W'(i_hist1) - SUM_W'(r_sample);
    assign w_sum_next = SUM_W'(i_hist0) - SUM_W'(i_newer);

    always_comb begin
        if (w_head) begin
            // oldest cell of the window opens the scan and judges the sums
            w_cur.valid = 1'b1;
            w_cur.ok    = w_rise && (w_sum_i > w_sum_next) && (w_sum_i < i_thr);
            w_cur.best  = '0;
            w_cur.jbest = '0;
        end else begin
            w_cur = i_tok;
        end
    end

    assign w_elig = w_cur.valid && w_rise && (r_sample > w_cur.best);

    always_comb begin
        n_tok = w_cur;
        if (w_elig) begin
            n_tok.best  = r_sample;
            n_tok.jbest = i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_newer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_sample = r_sample;
    assign o_tok    = r_tok;

endmodule

// ----- sv/sspd_checker.sv -----
// ---------------------------------------------------------------------------
// sspd_checker
// port-level checks for the slope sum peak detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "slope_sum_peak_detector_assert.svh"

module sspd_checker
    import sspd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    logic w_out_held;

    assign w_out_held = o_out_valid && i_out_stall;

    // a stalled result transaction keeps its payload
    `SSPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_out_valid && $stable(o_out_data))

    // every reported peak has been counted
    `SSPD_ASSERT_SAME(a_count_nonzero, i_clk, i_rst_n, o_out_valid, o_out_data.peak_count != '0)

    // a new result is only produced from the emit step, while input is held off
    `SSPD_ASSERT_SAME(a_emit_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // the config port never holds off a write
    `SSPD_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind slope_sum_peak_detector sspd_checker u_sspd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// slope sum peak detector testbench
// Drives framed sample streams through the detector and checks every peak
// result against an in-bench predictor. A short table of hand-built frames
// comes first. Random phases follow, each with its own register settings and
// idle pattern. A last frame of repeated peaks runs past the position
// capacity.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import sspd_pkg::*;

    localparam int HIST_DEPTH       = 34;
    localparam int DIRECTED_ROWS    = 25;
    localparam int PHASES           = 11;
    localparam int ITEMS_PER_PHASE  = 145;
    localparam int SAT_TRIPLES      = 12;
    localparam int SAT_CAPACITY     = 5;
    localparam int SETTLE_CYCLES    = 48;
    localparam int HOLD_CYCLES      = 600;
    localparam int QUIET_LIMIT      = 4000;
    localparam int REPORT_LIMIT     = 40;

    // index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_PEAK} t_row_kind;
    typedef enum logic [1:0] {PRESS_NONE, PRESS_HOLD, PRESS_DRAIN} t_pressure;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sof;
        t_row_kind                  kind;
        t_out_item                  peak;
    } t_dir_row;

    typedef struct {
        logic [WIN_CFG_W-1:0]     window;
        logic signed [THR_W-1:0]  thresh;
        logic [POS_W-1:0]         capacity;
        int                       in_pct;
        int                       out_pct;
        t_pressure                pressure;
    } t_phase;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_samples [0:HIST_DEPTH-1];
    int                         hist_count  = 0;
    logic [POS_W-1:0]           next_index  = '0;
    logic [POS_W-1:0]           frame_peaks = '0;
    logic [WIN_CFG_W-1:0]       win_cfg     = WINDOW_RESET;
    logic signed [THR_W-1:0]    thr_cfg     = THRESHOLD_RESET;
    logic [POS_W-1:0]           cap_cfg     = MAX_POS_RESET;

    t_out_item   pending_peaks [$];
    t_out_item   oldest_peak;
    int          fail_count    = 0;
    int unsigned quiet_cycles  = 0;
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    logic [7:0]  hold_ticket   = '0;
    logic [7:0]  hold_served   = '0;
    int          hold_left     = 0;

    slope_sum_peak_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // advances the predictor by one sample, returns 1 when a peak comes out
    function automatic bit predict_peak(input t_in_item it, output t_out_item res);
        int w;
        int n;
        int cand;
        int pos;
        int best;
        int sum_cur;
        int sum_nxt;
        int win [0:HIST_DEPTH-1];
        bit stored;
        res = '0;
        if (it.start_of_frame) begin
            hist_count  = 0;
            next_index  = '0;
            frame_peaks = '0;
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            hist_samples[k] = hist_samples[k-1];
        end
        hist_samples[0] = it.sample;
        if (hist_count < HIST_DEPTH) begin
            hist_count++;
        end
        n = int'(next_index);
        next_index = next_index + 1'b1;

        w = (win_cfg < 2) ? 2 : (win_cfg > 32) ? 32 : int'(win_cfg);
        if (hist_count < w + 2) begin
            return 1'b0;
        end
        // oldest sample of the window first
        for (int j = 0; j < w + 2; j++) begin
            win[j] = hist_samples[w + 1 - j];
        end
        sum_cur = win[w] - win[0];
        sum_nxt = win[w+1] - win[1];
        if (!(win[1] - win[0] > 0 && sum_cur > sum_nxt && win[w] - win[w-1] < 0 &&
              sum_cur < thr_cfg)) begin
            return 1'b0;
        end

        cand = (n - w - 1) & 'hFFFF;
        best = 0;
        pos  = cand;
        for (int j = 0; j < w; j++) begin
            if (win[j+1] - win[j] > 0 && win[j] > best) begin
                best = win[j];
                pos  = (cand + j) & 'hFFFF;
            end
        end
        stored = (frame_peaks < cap_cfg);
        if (frame_peaks != 16'hFFFF) begin
            frame_peaks = frame_peaks + 1'b1;
        end
        res.peak_position   = 16'(pos);
        res.peak_count      = frame_peaks;
        res.position_stored = stored;
        return 1'b1;
    endfunction

    task automatic send_sample(input t_in_item it, input t_row_kind kind,
                               input t_out_item typed_peak);
        t_out_item predicted;
        bit        has_peak;
        bit        took;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        has_peak = predict_peak(it, predicted);
        case (kind)
            ROW_MODEL: begin
                if (has_peak) begin
                    pending_peaks.push_back(predicted);
                end
            end
            ROW_PEAK: begin
                pending_peaks.push_back(typed_peak);
            end
            default: begin
            end
        endcase
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        bit ready_seen;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            ready_seen = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        case (idx)
            CFG_WINDOW_SIZE:   win_cfg = data[WIN_CFG_W-1:0];
            CFG_SUM_THRESHOLD: thr_cfg = data[THR_W-1:0];
            CFG_MAX_POSITIONS: cap_cfg = data[POS_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_peaks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string field, input int expv, input int actv);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $error("%s: expected %0d, got %0d", field, expv, actv);
        end
    endtask

    // receiver: random stall, plus a long hold when the stimulus asks for one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_ticket) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    // everything is stable at the falling edge, so the next rising edge's
    // transactions are decided here
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_peaks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $error("unexpected peak: position %0d count %0d stored %0d",
                               o_out_data.peak_position, o_out_data.peak_count,
                               o_out_data.position_stored);
                    end
                end else begin
                    oldest_peak = pending_peaks.pop_front();
                    if (o_out_data.peak_position !== oldest_peak.peak_position) begin
                        flag_mismatch("peak_position", oldest_peak.peak_position,
                                      o_out_data.peak_position);
                    end
                    if (o_out_data.peak_count !== oldest_peak.peak_count) begin
                        flag_mismatch("peak_count", oldest_peak.peak_count,
                                      o_out_data.peak_count);
                    end
                    if (o_out_data.position_stored !== oldest_peak.position_stored) begin
                        flag_mismatch("position_stored", oldest_peak.position_stored,
                                      o_out_data.position_stored);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_dir_row   directed_rows [DIRECTED_ROWS];
        t_phase     phase_plan [PHASES];
        t_phase     ph;
        t_in_item   item;
        logic [31:0] junk;
        int         rnd;
        int         pick;
        int         walk_level;
        int         walk_dir;
        int         b_val;
        int         c_val;

        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_samples[k] = '0;
        end
        walk_level = 0;
        walk_dir   = 1;

        // short frame of extremes, then a frame with one obvious peak at index 2
        directed_rows = '{
            '{16'sd32767,  1'b1, ROW_SILENT, '0},
            '{16'sh8000,   1'b0, ROW_SILENT, '0},
            '{16'sd32767,  1'b0, ROW_SILENT, '0},
            '{16'sh8000,   1'b0, ROW_SILENT, '0},
            '{16'sd0,      1'b0, ROW_SILENT, '0},
            '{-16'sd1,     1'b0, ROW_SILENT, '0},
            '{16'sd1,      1'b0, ROW_SILENT, '0},
            '{16'sd32767,  1'b0, ROW_SILENT, '0},
            '{16'sh8000,   1'b0, ROW_SILENT, '0},
            '{16'sd0,      1'b1, ROW_SILENT, '0},
            '{16'sd100,    1'b0, ROW_SILENT, '0},
            '{16'sd200,    1'b0, ROW_SILENT, '0},
            '{16'sd300,    1'b0, ROW_SILENT, '0},
            '{16'sd200,    1'b0, ROW_SILENT, '0},
            '{16'sd100,    1'b0, ROW_SILENT, '0},
            '{16'sd0,      1'b0, ROW_SILENT, '0},
            '{-16'sd50,    1'b0, ROW_SILENT, '0},
            '{-16'sd100,   1'b0, ROW_SILENT, '0},
            '{-16'sd1000,  1'b0, ROW_PEAK,   '{16'd2, 16'd1, 1'b1}},
            '{16'sd32767,  1'b0, ROW_MODEL,  '0},
            '{16'sh8000,   1'b0, ROW_MODEL,  '0},
            '{16'sd32767,  1'b0, ROW_MODEL,  '0},
            '{16'sh8000,   1'b0, ROW_MODEL,  '0},
            '{16'sd0,      1'b0, ROW_MODEL,  '0},
            '{-16'sd1,     1'b0, ROW_MODEL,  '0}
        };

        // window values 0, 1, 33 and 63 fall outside the legal range
        phase_plan = '{
            '{6'd2,  17'sd0,     16'd3,     0,  0,  PRESS_HOLD},
            '{6'd0,  17'sd65535, 16'd0,     71, 0,  PRESS_NONE},
            '{6'd63, 17'h10000,  16'd65535, 0,  71, PRESS_NONE},
            '{6'd32, -17'sd1,    16'd5,     26, 26, PRESS_NONE},
            '{6'd1,  -17'sd30,   16'd16,    0,  0,  PRESS_DRAIN},
            '{6'd33, 17'sd100,   16'd1,     71, 0,  PRESS_NONE},
            '{6'd5,  -17'sd200,  16'd2,     0,  71, PRESS_NONE},
            '{6'd16, 17'sd40,    16'd65535, 26, 26, PRESS_NONE},
            '{6'd3,  17'sd1000,  16'd8,     0,  0,  PRESS_NONE},
            '{6'd12, -17'sd5,    16'd4,     26, 26, PRESS_NONE},
            '{6'd0,  17'sd0,     16'd0,     26, 26, PRESS_NONE}
        };
        phase_plan[PHASES-1].window   = WIN_CFG_W'($urandom);
        phase_plan[PHASES-1].thresh   = THR_W'($urandom);
        phase_plan[PHASES-1].capacity = POS_W'($urandom_range(0, 40));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            item.sample         = directed_rows[r].sample;
            item.start_of_frame = directed_rows[r].sof;
            send_sample(item, directed_rows[r].kind, directed_rows[r].peak);
        end

        for (int p = 0; p < PHASES; p++) begin
            ph = phase_plan[p];
            drain_results(SETTLE_CYCLES);
            junk = $urandom;
            cfg_write(CFG_WINDOW_SIZE, {junk[10:0], ph.window});
            cfg_write(CFG_SUM_THRESHOLD, ph.thresh);
            cfg_write(CFG_MAX_POSITIONS, {junk[16], ph.capacity});
            if (p == 0) begin
                cfg_write(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
            end
            i_cfg_valid   <= 1'b0;
            in_idle_pct    = ph.in_pct;
            out_stall_pct <= ph.out_pct;
            if (ph.pressure == PRESS_HOLD) begin
                hold_ticket <= hold_ticket + 1'b1;
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph.pressure == PRESS_DRAIN && k == ITEMS_PER_PHASE / 2) begin
                    drain_results(0);
                end
                item.start_of_frame = ($urandom_range(0, 49) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // random walk with momentum gives rising and falling stretches
                    if ($urandom_range(0, 5) == 0) begin
                        walk_dir = -walk_dir;
                    end
                    walk_level = walk_level +
                                 walk_dir * int'($urandom_range(1, 1 << $urandom_range(0, 12)));
                    if (walk_level > 32767) begin
                        walk_level = 32767;
                        walk_dir   = -1;
                    end else if (walk_level < -32768) begin
                        walk_level = -32768;
                        walk_dir   = 1;
                    end
                    item.sample = 16'(walk_level);
                end else if (pick < 82) begin
                    item.sample = 16'($urandom);
                end else if (pick < 92) begin
                    case ($urandom_range(0, 4))
                        0:       item.sample = 16'sd32767;
                        1:       item.sample = 16'sh8000;
                        2:       item.sample = 16'sd0;
                        3:       item.sample = -16'sd1;
                        default: item.sample = 16'sd1;
                    endcase
                end else begin
                    rnd = $urandom_range(0, 100);
                    item.sample = 16'(rnd - 50);
                end
                send_sample(item, ROW_MODEL, '0);
            end
        end

        // one last frame, a peak every third sample, running past the
        // position capacity so the stored flag drops partway through
        drain_results(SETTLE_CYCLES);
        cfg_write(CFG_WINDOW_SIZE, CFG_DATA_W'(2));
        cfg_write(CFG_SUM_THRESHOLD, 17'sd65535);
        cfg_write(CFG_MAX_POSITIONS, CFG_DATA_W'(SAT_CAPACITY));
        i_cfg_valid   <= 1'b0;
        in_idle_pct    = 0;
        out_stall_pct <= 0;
        for (int t = 0; t < SAT_TRIPLES; t++) begin
            b_val = 4 + int'($urandom_range(0, 29996));
            c_val = b_val - int'($urandom_range(1, 2 * b_val - 7));
            item.sample         = 16'sd3;
            item.start_of_frame = (t == 0);
            send_sample(item, ROW_MODEL, '0);
            item.sample         = 16'(b_val);
            item.start_of_frame = 1'b0;
            send_sample(item, ROW_MODEL, '0);
            item.sample         = 16'(c_val);
            send_sample(item, ROW_MODEL, '0);
        end

        drain_results(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/sspd_pkg.sv
sv/sspd_cell.sv
sv/slope_sum_peak_detector.sv
sv/sspd_checker.sv
tb/testbench.sv
